@@ hw/rtl/lefsm_pkg.sv @@
// shared types, constants and command codes for the learnable edge state machine
package lefsm_pkg;

  localparam int SLOTS  = 256;
  localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PTR_W  = $clog2(SLOTS + 1);
  localparam int OCC_W  = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [2:0] CMD_STEP   = 3'd0;
  localparam logic [2:0] CMD_LEARN  = 3'd1;
  localparam logic [2:0] CMD_REMOVE = 3'd2;
  localparam logic [2:0] CMD_COUNT  = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;

  localparam logic [1:0] ST_NONE    = 2'd0;
  localparam logic [1:0] ST_EXISTS  = 2'd1;
  localparam logic [1:0] ST_DONE    = 2'd1;
  localparam logic [1:0] ST_CREATED = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_ID   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FREE_MARK = 1'd1;

  localparam logic [7:0] RESET_PAGE = 8'hFF;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] input_bits;
    logic [7:0] feedback_state;
    logic [7:0] next_state;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       present_state;
    logic [7:0]       last_feedback;
    logic             matched;
    logic [1:0]       status;
    logic [OCC_W-1:0] occupied;
  } out_item_t;

  typedef struct packed {
    logic [7:0] page;
    logic [7:0] change;
    logic [7:0] rise;
    logic [7:0] from_st;
    logic [7:0] to_st;
  } slot_rec_t;

  localparam int REC_W = $bits(slot_rec_t);

  typedef struct packed {
    logic init_wr;
    logic load;
    logic scan;
    logic finish;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic init_last;
    logic need_scan;
    logic scan_done;
  } dp_stat_t;

endpackage

@@ hw/rtl/lefsm_ram.sv @@
// generic single write port, single read port ram with registered read
module lefsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic                                      rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

@@ hw/rtl/lefsm_ctrl.sv @@
// controller state machine: clearing pass, item intake, table scan and result handoff
module lefsm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  lefsm_pkg::dp_stat_t st,
  output lefsm_pkg::ctl_cmd_t ctl
);
  import lefsm_pkg::*;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_FINISH,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    ctl           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_INIT: begin
        ctl.init_wr = 1'b1;
        if (st.init_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          ctl.load  = 1'b1;
          state_nxt = st.need_scan ? S_SCAN : S_FINISH;
        end
      end
      S_SCAN: begin
        ctl.scan = 1'b1;
        if (st.scan_done) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        ctl.finish = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        // previous result must be gone before this one takes the register
        if (!out_valid_r || !out_stall) begin
          ctl.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

@@ hw/rtl/lefsm_dp.sv @@
// datapath: config registers, machine state, slot table ram, scan evaluation, result register
module lefsm_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  lefsm_pkg::ctl_cmd_t                   ctl,
  output lefsm_pkg::dp_stat_t                   st,
  input  logic                                  cfg_wr_en,
  input  logic [lefsm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lefsm_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  lefsm_pkg::in_item_t                   in_data,
  output lefsm_pkg::out_item_t                  out_data
);
  import lefsm_pkg::*;

  logic [7:0] page_id_r, page_id_nxt;
  logic [7:0] free_mark_r, free_mark_nxt;
  logic [7:0] prior_r, prior_nxt;
  logic [7:0] cur_r, cur_nxt;
  logic [7:0] fbk_r, fbk_nxt;
  logic       match_r, match_nxt;

  logic [2:0] cmd_r;
  logic [7:0] chg_r, rise_r, fb_in_r, nxt_in_r;
  logic       scanned_r;

  logic [PTR_W-1:0]  ptr_r;
  logic              eval_vld_r;
  logic [ADDR_W-1:0] eval_idx_r;
  logic              hit_r, free_found_r;
  logic [ADDR_W-1:0] free_idx_r;
  logic [1:0]        status_r;
  logic [OCC_W-1:0]  cnt_r;
  out_item_t         out_r;

  logic [7:0]        chg_in, rise_in;
  logic              edge_cmd, need_scan;
  logic              issue, ev, page_own, rec_hit, is_free, last_idx, stop;
  slot_rec_t         q, wr_rec;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;

  assign chg_in    = prior_r ^ in_data.input_bits;
  assign rise_in   = chg_in & in_data.input_bits;
  assign edge_cmd  = (in_data.command == CMD_STEP) || (in_data.command == CMD_LEARN) ||
                     (in_data.command == CMD_REMOVE);
  assign need_scan = (edge_cmd && (chg_in != 8'd0)) || (in_data.command == CMD_COUNT) ||
                     (in_data.command == CMD_CLEAR);

  // read one slot a cycle; its record is judged the cycle after
  assign issue    = ctl.scan && (ptr_r < PTR_W'(SLOTS));
  assign ev       = ctl.scan && eval_vld_r;
  assign page_own = (q.page == page_id_r);
  assign rec_hit  = page_own && (q.change == chg_r) && (q.rise == rise_r) &&
                    (q.from_st == fb_in_r);
  assign is_free  = (q.page == free_mark_r);
  assign last_idx = (eval_idx_r == ADDR_W'(SLOTS - 1));
  assign stop     = rec_hit && ((cmd_r == CMD_STEP) || (cmd_r == CMD_LEARN) ||
                                (cmd_r == CMD_REMOVE));

  assign st.init_last = (ptr_r == PTR_W'(SLOTS - 1));
  assign st.need_scan = need_scan;
  assign st.scan_done = ev && (stop || last_idx);

  lefsm_ram #(
    .WIDTH (REC_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_rec),
    .rd_en   (issue),
    .rd_addr (ptr_r[ADDR_W-1:0]),
    .rd_data (q)
  );

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ptr_r[ADDR_W-1:0];
    wr_rec  = '0;
    if (ctl.init_wr) begin
      wr_en       = 1'b1;
      wr_rec.page = RESET_PAGE;
    end else if (ev && (((cmd_r == CMD_REMOVE) && rec_hit) ||
                        ((cmd_r == CMD_CLEAR) && !is_free))) begin
      wr_en       = 1'b1;
      wr_addr     = eval_idx_r;
      wr_rec      = q;
      wr_rec.page = free_mark_r;
    end else if (ctl.finish && (cmd_r == CMD_LEARN) && scanned_r && !hit_r &&
                 free_found_r) begin
      wr_en          = 1'b1;
      wr_addr        = free_idx_r;
      wr_rec.page    = page_id_r;
      wr_rec.change  = chg_r;
      wr_rec.rise    = rise_r;
      wr_rec.from_st = fb_in_r;
      wr_rec.to_st   = nxt_in_r;
    end
  end

  always_comb begin
    page_id_nxt   = page_id_r;
    free_mark_nxt = free_mark_r;
    prior_nxt     = prior_r;
    cur_nxt       = cur_r;
    fbk_nxt       = fbk_r;
    match_nxt     = match_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_PAGE_ID:   page_id_nxt   = cfg_wdata;
        CFG_FREE_MARK: free_mark_nxt = cfg_wdata;
        default:       page_id_nxt   = page_id_r;
      endcase
    end
    if (ctl.load) begin
      if ((in_data.command == CMD_LEARN) || (edge_cmd && (chg_in != 8'd0))) begin
        prior_nxt = in_data.input_bits;
      end
    end
    if (ev && (cmd_r == CMD_STEP) && page_own) begin
      if (rec_hit) begin
        cur_nxt   = q.to_st;
        fbk_nxt   = q.from_st;
        match_nxt = 1'b1;
      end else begin
        fbk_nxt   = cur_r;
        match_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_id_r   <= '0;
      free_mark_r <= RESET_PAGE;
      prior_r     <= '0;
      cur_r       <= '0;
      fbk_r       <= '0;
      match_r     <= 1'b0;
      ptr_r       <= '0;
      eval_vld_r  <= 1'b0;
    end else begin
      page_id_r   <= page_id_nxt;
      free_mark_r <= free_mark_nxt;
      prior_r     <= prior_nxt;
      cur_r       <= cur_nxt;
      fbk_r       <= fbk_nxt;
      match_r     <= match_nxt;
      eval_vld_r  <= issue;
      if (ctl.load) begin
        ptr_r <= '0;
      end else if (ctl.init_wr || issue) begin
        ptr_r <= ptr_r + PTR_W'(1);
      end
    end
  end

  // per-item scratch, loaded or cleared when the item is taken
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r        <= in_data.command;
      chg_r        <= chg_in;
      rise_r       <= rise_in;
      fb_in_r      <= in_data.feedback_state;
      nxt_in_r     <= in_data.next_state;
      scanned_r    <= need_scan;
      hit_r        <= 1'b0;
      free_found_r <= 1'b0;
      status_r     <= ST_NONE;
      cnt_r        <= '0;
    end
    if (issue) begin
      eval_idx_r <= ptr_r[ADDR_W-1:0];
    end
    if (ev) begin
      case (cmd_r)
        CMD_LEARN: begin
          if (rec_hit) begin
            hit_r <= 1'b1;
          end
          if (is_free && !free_found_r) begin
            free_found_r <= 1'b1;
            free_idx_r   <= eval_idx_r;
          end
        end
        CMD_REMOVE: begin
          if (rec_hit) begin
            status_r <= ST_DONE;
          end
        end
        CMD_COUNT: begin
          if (!is_free && (cnt_r != '1)) begin
            cnt_r <= cnt_r + OCC_W'(1);
          end
        end
        CMD_CLEAR: begin
          if (!is_free) begin
            status_r <= ST_DONE;
          end
        end
        default: begin
          cnt_r <= cnt_r;
        end
      endcase
    end
    if (ctl.finish && (cmd_r == CMD_LEARN) && scanned_r) begin
      if (hit_r) begin
        status_r <= ST_EXISTS;
      end else if (free_found_r) begin
        status_r <= ST_CREATED;
      end else begin
        status_r <= ST_FULL;
      end
    end
    if (ctl.out_load) begin
      out_r.present_state <= cur_r;
      out_r.last_feedback <= fbk_r;
      out_r.matched       <= match_r;
      out_r.status        <= status_r;
      out_r.occupied      <= cnt_r;
    end
  end

  assign out_data = out_r;

endmodule

@@ hw/rtl/learnable_edge_fsm_table_top.sv @@
// top level of the learnable edge state machine with its transition table
//
//  channel | dir | ports                                  | item
//  --------+-----+----------------------------------------+---------------------------
//  in      | in  | in_valid, in_stall, in_data            | command and input vector
//  out     | out | out_valid, out_stall, out_data         | state, feedback, status
//  cfg     | in  | cfg_wr_en, cfg_index, cfg_wdata        | page_id, free_mark writes
//
//  a step, learn or remove with a changed input, a count and a clear all read the slot ram
//  once per slot (a step, learn or remove stops early on a hit); other items do not scan.
//  after reset a clearing pass writes every slot as free, with in_stall high.
//  the result sits in an output register; a stalled output holds back the next result and later items.
module learnable_edge_fsm_table_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  lefsm_pkg::in_item_t                   in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output lefsm_pkg::out_item_t                  out_data,
  input  logic                                  cfg_wr_en,
  input  logic [lefsm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lefsm_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import lefsm_pkg::*;

  ctl_cmd_t ctl;
  dp_stat_t st;

  lefsm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .ctl       (ctl)
  );

  lefsm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .st        (st),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_data  (out_data)
  );

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ctl.init_wr, ctl.load, ctl.scan, ctl.finish, ctl.out_load}))
    else $error("controller issued more than one datapath command");

  a_load_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load |=> (ctl.scan || ctl.finish))
    else $error("taken item neither scanned nor finished");

  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_load |=> out_valid)
    else $error("loaded result not presented");

  a_no_intake_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.scan || ctl.init_wr) |-> in_stall)
    else $error("input open while table busy");

endmodule
